@@ rtl/bas_pkg.sv @@
// Shared constants, payload types, sequencer states and byte compare of the byte array sorter.
package bas_pkg;

  // Capacity of the byte store and the counter widths that follow from it.
  localparam int MaxItems = 64;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int ByteW    = 8;

  // Configuration register indexes.
  localparam int RegSignedOrder = 0;

  // One input word.
  typedef struct packed {
    logic [ByteW-1:0] data_value;
    logic             last_item;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [ByteW-1:0] sorted_value;
    logic             last_result;
    logic             overflow;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GETV,
    ST_CMP,
    ST_PUT,
    ST_EMIT
  } state_t;

  // True when byte a sorts after byte b; signed order flips the top bit first.
  function automatic logic key_gt(input logic [ByteW-1:0] a,
                                  input logic [ByteW-1:0] b,
                                  input logic             sgn);
    logic [ByteW-1:0] ka;
    logic [ByteW-1:0] kb;
    ka = a ^ {sgn, {(ByteW-1){1'b0}}};
    kb = b ^ {sgn, {(ByteW-1){1'b0}}};
    return ka > kb;
  endfunction

endpackage

@@ rtl/bas_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/byte_array_sorter_unit.sv @@
// Byte array sorter: collects a set of bytes and returns them in ascending order.
// Words load back to back; busy stays low between words of a set.
// After the last word, an insertion sort in the store uses one compare per cycle;
// then the n stored bytes are emitted as n result words.
// Results appear one per cycle and cannot be stalled; busy drops as the last one shows.
// Reset (rst_n low, synchronous) empties the set and clears signed_order; the store keeps data.
module byte_array_sorter_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  bas_pkg::in_word_t  in_data,
  // Result channel
  output logic               out_valid,
  output bas_pkg::out_word_t out_data,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bas_pkg::state_t                state_r, state_nxt;
  logic [bas_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  logic                           drop_r, drop_nxt;
  logic [bas_pkg::CntW-1:0]       i_r, i_nxt;
  logic [bas_pkg::IdxW-1:0]       j_r, j_nxt;
  logic [bas_pkg::ByteW-1:0]      v_r, v_nxt;
  logic [bas_pkg::CntW-1:0]       e_r, e_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bas_pkg::out_word_t             out_data_r, out_data_nxt;
  logic                           sgn_r;

  logic                           we;
  logic [bas_pkg::IdxW-1:0]       waddr;
  logic [bas_pkg::ByteW-1:0]      wdata;
  logic [bas_pkg::IdxW-1:0]       raddr;
  logic [bas_pkg::ByteW-1:0]      rdata;
  logic                           cfg_wr;

  // Byte store.
  bas_ram #(
    .WIDTH (bas_pkg::ByteW),
    .DEPTH (bas_pkg::MaxItems)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration register write and read back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r <= 1'b0;
    end else if (cfg_wr && (paddr[2] == 1'(bas_pkg::RegSignedOrder))) begin
      sgn_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'(bas_pkg::RegSignedOrder)) ? {31'b0, sgn_r} : 32'b0;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bas_pkg::ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    v_r        <= v_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer: load, insertion sort in the store, then emit in address order.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    v_nxt         = v_r;
    e_nxt         = e_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = cnt_r[bas_pkg::IdxW-1:0];
    wdata         = in_data.data_value;
    raddr         = '0;

    unique case (state_r)
      bas_pkg::ST_IDLE: begin
        if (start) begin
          // Store the byte while there is room, otherwise note the drop.
          if (cnt_r < bas_pkg::CntW'(bas_pkg::MaxItems)) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + bas_pkg::CntW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            i_nxt     = bas_pkg::CntW'(1);
            state_nxt = bas_pkg::ST_FETCH;
          end
        end
      end

      bas_pkg::ST_FETCH: begin
        // Read the next byte to insert, or start emitting when all are placed.
        if (i_r == cnt_r) begin
          raddr     = '0;
          e_nxt     = bas_pkg::CntW'(1);
          state_nxt = bas_pkg::ST_EMIT;
        end else begin
          raddr     = i_r[bas_pkg::IdxW-1:0];
          state_nxt = bas_pkg::ST_GETV;
        end
      end

      bas_pkg::ST_GETV: begin
        // Capture the byte being inserted and read its left neighbor.
        v_nxt     = rdata;
        j_nxt     = i_r[bas_pkg::IdxW-1:0];
        raddr     = i_r[bas_pkg::IdxW-1:0] - bas_pkg::IdxW'(1);
        state_nxt = bas_pkg::ST_CMP;
      end

      bas_pkg::ST_CMP: begin
        // One compare per cycle: shift the larger neighbor right or drop the byte in.
        we    = 1'b1;
        waddr = j_r;
        if (bas_pkg::key_gt(rdata, v_r, sgn_r)) begin
          wdata = rdata;
          j_nxt = j_r - bas_pkg::IdxW'(1);
          if (j_r == bas_pkg::IdxW'(1)) begin
            state_nxt = bas_pkg::ST_PUT;
          end else begin
            raddr = j_r - bas_pkg::IdxW'(2);
          end
        end else begin
          wdata     = v_r;
          i_nxt     = i_r + bas_pkg::CntW'(1);
          state_nxt = bas_pkg::ST_FETCH;
        end
      end

      bas_pkg::ST_PUT: begin
        // The byte is the smallest so far: it goes to the front.
        we        = 1'b1;
        waddr     = '0;
        wdata     = v_r;
        i_nxt     = i_r + bas_pkg::CntW'(1);
        state_nxt = bas_pkg::ST_FETCH;
      end

      bas_pkg::ST_EMIT: begin
        // Read data holds the byte at address e_r - 1.
        out_valid_nxt             = 1'b1;
        out_data_nxt.sorted_value = rdata;
        out_data_nxt.last_result  = (e_r == cnt_r);
        out_data_nxt.overflow     = drop_r;
        if (e_r == cnt_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = bas_pkg::ST_IDLE;
        end else begin
          raddr = e_r[bas_pkg::IdxW-1:0];
          e_nxt = e_r + bas_pkg::CntW'(1);
        end
      end

      default: begin
        state_nxt = bas_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != bas_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The fill count never passes the store capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bas_pkg::CntW'(bas_pkg::MaxItems))
    else $error("fill count above capacity");

  // A word that closes a set makes the block busy.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_item |=> busy)
    else $error("not busy after the last word of a set");

  // The last result leaves the block idle and empty.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> !busy && (cnt_r == '0) && !drop_r)
    else $error("set not cleared after its last result");

  // Results appear only while the block is idle or emitting.
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == bas_pkg::ST_EMIT) || (state_r == bas_pkg::ST_IDLE))
    else $error("result word outside the emit phase");
`endif

endmodule
